// File: rtl/nonce_replay_cache_unit_macros.svh
// Assertion macros for the nonce replay cache unit.
// Used by the controller and datapath modules; relies on clk_i and rst_ni in scope.
`ifndef NONCE_REPLAY_CACHE_UNIT_MACROS_SVH
`define NONCE_REPLAY_CACHE_UNIT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define NRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be true outside reset.
`define NRC_ASSERT_NEVER(lbl, cond, msg) \
  `NRC_ASSERT(lbl, !(cond), msg)
`else
`define NRC_ASSERT(lbl, prop, msg)
`define NRC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: rtl/nrc_pkg.sv
// Shared types and constants of the nonce replay cache unit.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none
package nrc_pkg;

  localparam int unsigned NONCE_W = 32;
  localparam int unsigned TIME_W  = 31;

  // Operation codes of a request.
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request and clear the scan state
    logic issue;   // read the slot at the scan counter and advance it
    logic commit;  // write back an add and present the result
  } nrc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_last;  // the scan counter points at the last slot
  } nrc_sts_t;

endpackage
`default_nettype wire

// File: rtl/nrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module nrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/nrc_ctrl.sv
// Controller state machine of the nonce replay cache unit.
// Depends on nrc_pkg and the assertion macro header.
`default_nettype none
`include "nonce_replay_cache_unit_macros.svh"
module nrc_ctrl
  import nrc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  output nrc_cmd_t      cmd_o,
  input  wire nrc_sts_t sts_i
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last slot's read data is evaluated in this cycle.
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  `NRC_ASSERT(a_start_scan, (state_q == S_IDLE && start) |=> (state_q == S_SCAN), "Accepted request did not start a scan.")
  `NRC_ASSERT(a_drain_after_last, (state_q == S_DRAIN) |-> $past(cmd_o.issue && sts_i.cnt_last), "Drain entered before the last slot was read.")
  `NRC_ASSERT(a_commit_once, (state_q == S_COMMIT) |=> (state_q == S_IDLE), "Commit did not return to idle.")

endmodule
`default_nettype wire

// File: rtl/nrc_dp.sv
// Datapath of the nonce replay cache unit: valid bits, slot RAM, scan and result.
// Depends on nrc_pkg, nrc_ram and the assertion macro header.
`default_nettype none
`include "nonce_replay_cache_unit_macros.svh"
module nrc_dp
  import nrc_pkg::*;
#(
  parameter int unsigned ENTRIES = 16,
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire nrc_cmd_t           cmd_i,
  output nrc_sts_t                sts_o,
  input  wire logic               operation_i,
  input  wire logic [NONCE_W-1:0] nonce_value_i,
  input  wire logic [TIME_W-1:0]  expiry_time_i,
  input  wire logic [TIME_W-1:0]  current_time_i,
  output logic                    done_o,
  output logic                    fresh_o,
  output logic                    evicted_o
);

  localparam int unsigned WORD_W = NONCE_W + TIME_W;

  // Captured request.
  logic               op_q;
  logic [NONCE_W-1:0] nonce_q;
  logic [TIME_W-1:0]  exp_q;
  logic [TIME_W-1:0]  now_q;

  // Scan state.
  logic [IW-1:0]      cnt_q;
  logic               eval_vld_q;
  logic [IW-1:0]      eval_idx_q;
  logic [ENTRIES-1:0] valid_q, valid_d;

  // Accumulators over the scan.
  logic               found_q;
  logic               free_found_q;
  logic [IW-1:0]      free_idx_q;
  logic               best_any_q;
  logic [IW-1:0]      best_idx_q;
  logic [TIME_W-1:0]  best_exp_q;

  // Result registers.
  logic done_q, fresh_q, evicted_q;

  // Slot RAM signals.
  logic [WORD_W-1:0]  rdata;
  logic [NONCE_W-1:0] ent_nonce;
  logic [TIME_W-1:0]  ent_exp;
  logic               ent_v;
  logic               ram_we;
  logic [IW-1:0]      slot;

  assign ent_nonce = rdata[WORD_W-1:TIME_W];
  assign ent_exp   = rdata[TIME_W-1:0];
  assign ent_v     = valid_q[eval_idx_q];
  assign slot      = free_found_q ? free_idx_q : best_idx_q;
  assign ram_we    = cmd_i.commit && (op_q == OP_ADD);

  nrc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i ({nonce_q, exp_q}),
    .raddr_i (cnt_q),
    .rdata_o (rdata)
  );

  assign sts_o.cnt_last = (cnt_q == IW'(ENTRIES - 1));

  // Request capture; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      nonce_q <= nonce_value_i;
      exp_q   <= expiry_time_i;
      now_q   <= current_time_i;
    end
  end

  // Valid bits: a check purges expired entries as they are scanned, an add sets its slot.
  always_comb begin
    valid_d = valid_q;
    if (eval_vld_q && (op_q == OP_CHECK) && ent_v && (ent_exp <= now_q)) begin
      valid_d[eval_idx_q] = 1'b0;
    end
    if (ram_we) begin
      valid_d[slot] = 1'b1;
    end
  end

  // Scan counter, read pipeline, accumulators and result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      cnt_q        <= '0;
      eval_vld_q   <= 1'b0;
      eval_idx_q   <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      best_any_q   <= 1'b0;
      best_idx_q   <= '0;
      best_exp_q   <= '0;
      done_q       <= 1'b0;
      fresh_q      <= 1'b0;
      evicted_q    <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      eval_vld_q <= cmd_i.issue;
      eval_idx_q <= cnt_q;
      if (cmd_i.load) begin
        cnt_q        <= '0;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
        best_any_q   <= 1'b0;
      end else if (cmd_i.issue) begin
        cnt_q <= cnt_q + IW'(1);
      end
      // Evaluate the slot whose data arrived from the RAM this cycle.
      if (eval_vld_q) begin
        if (ent_v && (ent_nonce == nonce_q)) begin
          found_q <= 1'b1;
        end
        if (!ent_v && !free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q   <= eval_idx_q;
        end
        // Strict compare keeps the lowest slot on an expiry tie.
        if (ent_v && (!best_any_q || (ent_exp < best_exp_q))) begin
          best_any_q <= 1'b1;
          best_idx_q <= eval_idx_q;
          best_exp_q <= ent_exp;
        end
      end
      done_q <= cmd_i.commit;
      if (cmd_i.commit) begin
        fresh_q   <= (op_q == OP_CHECK) && !found_q;
        evicted_q <= (op_q == OP_ADD) && !free_found_q;
      end
    end
  end

  assign done_o    = done_q;
  assign fresh_o   = fresh_q;
  assign evicted_o = evicted_q;

  `NRC_ASSERT(a_done_from_commit, done_q |-> $past(cmd_i.commit), "Result strobe without a commit.")
  `NRC_ASSERT_NEVER(a_flags_exclusive, done_q && fresh_q && evicted_q, "Fresh and evicted set together.")
  `NRC_ASSERT(a_add_sets_valid, ram_we |=> valid_q[$past(slot)], "Written slot not marked valid.")

endmodule
`default_nettype wire

// File: rtl/nonce_replay_cache_unit.sv
// Top level of the nonce replay cache unit: controller plus datapath.
// Depends on nrc_pkg, nrc_ctrl, nrc_dp and nrc_ram.
//
//   Channel   Handshake          Fields
//   request   start / busy       operation_i, nonce_value_i, expiry_time_i, current_time_i
//   result    done_o (strobe)    fresh_o, evicted_o
//
// A request is accepted in the idle state and then passes through the scan, drain and
// commit states: one slot is read from the slot RAM per cycle, the drain state drains
// the registered read, the commit state commits, and the controller returns to idle,
// in which it can accept again. The result strobe comes in that idle cycle and may
// overlap the next request's acceptance.
// Reset clears all valid bits at once, so the table is empty with no clearing pass.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
module nonce_replay_cache_unit
  import nrc_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               operation_i,
  input  wire logic signed [NONCE_W-1:0] nonce_value_i,
  input  wire logic [TIME_W-1:0]  expiry_time_i,
  input  wire logic [TIME_W-1:0]  current_time_i,
  output logic                    done_o,
  output logic                    fresh_o,
  output logic                    evicted_o
);

  nrc_cmd_t cmd;
  nrc_sts_t sts;

  nrc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  nrc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (operation_i),
    .nonce_value_i  (nonce_value_i),
    .expiry_time_i  (expiry_time_i),
    .current_time_i (current_time_i),
    .done_o         (done_o),
    .fresh_o        (fresh_o),
    .evicted_o      (evicted_o)
  );

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the nonce replay cache unit.
// Depends on nrc_pkg and nonce_replay_cache_unit. A scoreboard class predicts each verdict
// from its own copy of the slot table, and plain tasks drive the request port.
`default_nettype none
module tb;
  import nrc_pkg::*;

  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_REQS = 1000;
  localparam int unsigned MAX_REPORTS = 10;

  // Expected outcome of one request.
  typedef struct {
    logic fresh;
    logic evicted;
  } verdict_t;

  // Predicts verdicts from a private copy of the slot table and checks results in order.
  class replay_scoreboard;
    bit                 slot_used [ENTRIES];
    logic [NONCE_W-1:0] slot_nonce[ENTRIES];
    logic [TIME_W-1:0]  slot_exp  [ENTRIES];
    verdict_t           verdict_q[$];
    int                 mismatches;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      mismatches = 0;
    endfunction

    // Work out the verdict of an accepted request and update the table copy.
    function void note_request(logic op, logic [NONCE_W-1:0] nonce,
                               logic [TIME_W-1:0] expiry, logic [TIME_W-1:0] now);
      verdict_t v;
      int       target;
      v.fresh   = 1'b0;
      v.evicted = 1'b0;
      if (op == OP_ADD) begin
        // Lowest free slot first; otherwise the earliest expiry, lowest index on a tie.
        target = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (target < 0 && !slot_used[i]) target = i;
        end
        if (target < 0) begin
          target = 0;
          for (int i = 1; i < ENTRIES; i++) begin
            if (slot_exp[i] < slot_exp[target]) target = i;
          end
          v.evicted = 1'b1;
        end
        slot_used[target]  = 1'b1;
        slot_nonce[target] = nonce;
        slot_exp[target]   = expiry;
      end else begin
        // The lookup sees the table as it was before this purge.
        v.fresh = 1'b1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i] && slot_nonce[i] == nonce) v.fresh = 1'b0;
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i] && slot_exp[i] <= now) slot_used[i] = 1'b0;
        end
      end
      verdict_q.push_back(v);
    endfunction

    // Compare one result strobe with the oldest outstanding verdict.
    function void check_result(logic fresh, logic evicted);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: fresh=%0b evicted=%0b", fresh, evicted);
        return;
      end
      v = verdict_q.pop_front();
      if (fresh !== v.fresh || evicted !== v.evicted) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: expected fresh=%0b evicted=%0b, got fresh=%0b evicted=%0b",
                   v.fresh, v.evicted, fresh, evicted);
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               operation_i;
  logic [NONCE_W-1:0] nonce_value_i;
  logic [TIME_W-1:0]  expiry_time_i;
  logic [TIME_W-1:0]  current_time_i;
  logic               done_o;
  logic               fresh_o;
  logic               evicted_o;

  replay_scoreboard   sb;
  bit                 burst_mode;
  int unsigned        idle_cycles = 0;
  logic [NONCE_W-1:0] seen_nonces[$];

  nonce_replay_cache_unit #(
    .ENTRIES(ENTRIES)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .nonce_value_i (nonce_value_i),
    .expiry_time_i (expiry_time_i),
    .current_time_i(current_time_i),
    .done_o        (done_o),
    .fresh_o       (fresh_o),
    .evicted_o     (evicted_o)
  );

  // Free-running clock, period 12.
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Note accepted requests and check result strobes on the pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy)
      sb.note_request(operation_i, nonce_value_i, expiry_time_i, current_time_i);
    if (rst_ni && done_o) sb.check_result(fresh_o, evicted_o);
  end

  // Watchdog on cycles in which no request and no result moves.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Present one request after a random gap and hold it until accepted.
  task automatic issue_request(input logic op, input logic [NONCE_W-1:0] nonce,
                               input logic [TIME_W-1:0] expiry,
                               input logic [TIME_W-1:0] now);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 18);
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    operation_i    <= op;
    nonce_value_i  <= nonce;
    expiry_time_i  <= expiry;
    current_time_i <= now;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Stop sending until every outstanding result has arrived.
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
    @(posedge clk_i);
  endtask

  // Field extremes, duplicates, compare before purge, free slot reuse and an eviction tie.
  task automatic run_directed();
    issue_request(OP_CHECK, 32'h0000_0000, 31'h0, 31'h0);
    issue_request(OP_ADD, 32'h8000_0000, 31'h7FFF_FFFF, 31'h0);
    issue_request(OP_ADD, 32'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF);
    issue_request(OP_ADD, 32'hFFFF_FFFF, 31'd5, 31'h0);
    issue_request(OP_ADD, 32'h7FFF_FFFF, 31'd10, 31'h0);
    issue_request(OP_CHECK, 32'h8000_0000, 31'h7FFF_FFFF, 31'd0);
    issue_request(OP_CHECK, 32'h7FFF_FFFF, 31'h0, 31'd0);
    issue_request(OP_CHECK, 32'hFFFF_FFFF, 31'h0, 31'd5);
    issue_request(OP_CHECK, 32'hFFFF_FFFF, 31'h0, 31'd5);
    // Fill every free slot with the same expiry, then force a tied eviction.
    for (int k = 0; k < 14; k++) begin
      issue_request(OP_ADD, 32'h1000_0000 + k, 31'd7, 31'h0);
    end
    issue_request(OP_ADD, 32'h2000_0000, 31'd8, 31'h0);
    issue_request(OP_CHECK, 32'h1000_0000, 31'h0, 31'h7FFF_FFFF);
  endtask

  // Mostly plausible traffic around a moving clock, with some full-range noise.
  task automatic run_random();
    logic               op;
    logic [NONCE_W-1:0] nonce;
    logic [TIME_W-1:0]  expiry;
    logic [TIME_W-1:0]  now;
    logic [TIME_W-1:0]  clock_now;
    clock_now = '0;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if (n % 250 == 125) drain_results();
      clock_now = clock_now + TIME_W'($urandom_range(0, 6));
      op = ($urandom_range(0, 9) < 6) ? OP_ADD : OP_CHECK;
      if (seen_nonces.size() != 0 && $urandom_range(0, 2) != 0) begin
        nonce = seen_nonces[$urandom_range(0, seen_nonces.size() - 1)];
      end else begin
        nonce = $urandom();
      end
      expiry = clock_now + TIME_W'($urandom_range(0, 60));
      now    = clock_now;
      if ($urandom_range(0, 15) == 0) expiry = TIME_W'($urandom());
      if ($urandom_range(0, 31) == 0) now = TIME_W'($urandom());
      if (op == OP_ADD) begin
        seen_nonces.push_back(nonce);
        if (seen_nonces.size() > 24) void'(seen_nonces.pop_front());
      end
      issue_request(op, nonce, expiry, now);
    end
  endtask

  // Reset, stimulus, drain and final verdict.
  initial begin
    sb             = new();
    burst_mode     = 1'b0;
    rst_ni         = 1'b0;
    start          = 1'b0;
    operation_i    = OP_ADD;
    nonce_value_i  = '0;
    expiry_time_i  = '0;
    current_time_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    drain_results();
    repeat (ENTRIES + 8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
